FILE: rtl/core/bls_pkg.sv
// bounded lifo stack: shared constants, codes and controller/datapath interface types
// no dependencies; imported by bls_ctrl, bls_dpath and bounded_lifo_stack_core
package bls_pkg;

    localparam int unsigned DEPTH  = 64;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = ADDR_W + 1;
    localparam int unsigned DATA_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_DUMP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_EMIT = 2'd2
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic             out_free;
        logic             res_last;
        logic [CNT_W-1:0] fill;
    } dp_stat_t;

endpackage

FILE: rtl/core/bls_ctrl.sv
// bounded lifo stack controller: sequences accept, execute and result emission
// depends on bls_pkg
module bls_ctrl
    import bls_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free && stat.res_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        ctl.accept = 1'b0;
        ctl.exec   = 1'b0;
        ctl.emit   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                ctl.accept = in_valid;
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
            end
            S_EMIT:
            begin
                ctl.emit = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/bls_dpath.sv
// bounded lifo stack datapath: entry memory, fill count, capacity and output register
// depends on bls_pkg
module bls_dpath
    import bls_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  ctl,
    output dp_stat_t                 stat,
    input  logic [1:0]               cmd,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     cfg_valid,
    input  logic [CNT_W-1:0]         capacity,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] data,
    output logic [ADDR_W-1:0]        position,
    output logic                     last
);

    logic [DATA_W-1:0] entries_mem [DEPTH];

    cmd_t                     cmd_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic [CNT_W-1:0]         cap_reg;
    status_t                  res_status_reg;
    status_t                  res_status_next;
    logic [ADDR_W-1:0]        res_pos_reg;
    logic [ADDR_W-1:0]        idx_reg;
    logic [DATA_W-1:0]        rd_data_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  out_status_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic [ADDR_W-1:0]        out_pos_reg;
    logic                     out_last_reg;

    logic [CNT_W-1:0]  usable;
    logic [CNT_W-1:0]  top_cnt;
    logic              full;
    logic              empty;
    logic              push_ok;
    logic              pop_ok;
    logic              res_ok;
    logic              dump_last;
    logic              res_last;
    logic              advance;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_free;

    assign usable    = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;
    assign full      = (fill_reg >= usable);
    assign empty     = (fill_reg == '0);
    assign top_cnt   = fill_reg - CNT_W'(1);
    assign push_ok   = ctl.exec && (cmd_reg == CMD_PUSH) && !full;
    assign pop_ok    = ctl.exec && (cmd_reg == CMD_POP) && !empty;
    assign res_ok    = (res_status_reg == ST_OK);
    assign dump_last = ({1'b0, idx_reg} + CNT_W'(1)) == fill_reg;
    assign res_last  = !res_ok || (cmd_reg != CMD_DUMP) || dump_last;
    assign out_free  = !out_valid_reg || !out_stall;
    // dump: fetch the next entry while the current one goes out
    assign advance   = ctl.emit && res_ok && (cmd_reg == CMD_DUMP) && !dump_last;
    assign rd_en     = ctl.exec || advance;

    always_comb
    begin
        if (ctl.exec)
        begin
            rd_addr = (cmd_reg == CMD_DUMP) ? '0 : top_cnt[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = idx_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_PUSH: res_status_next = full ? ST_FULL : ST_OK;
            CMD_POP:  res_status_next = empty ? ST_EMPTY : ST_OK;
            CMD_PEEK: res_status_next = empty ? ST_EMPTY : ST_OK;
            CMD_DUMP: res_status_next = empty ? ST_EMPTY : ST_OK;
            default:  res_status_next = ST_EMPTY;
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (push_ok)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop_ok)
        begin
            fill_next = top_cnt;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                cap_reg <= capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entries_mem[fill_reg[ADDR_W-1:0]] <= value_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= entries_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg   <= cmd_t'(cmd);
            value_reg <= value;
        end
        if (ctl.exec)
        begin
            res_status_reg <= res_status_next;
            res_pos_reg    <= fill_reg[ADDR_W-1:0];
            idx_reg        <= '0;
        end
        else if (advance)
        begin
            idx_reg <= idx_reg + ADDR_W'(1);
        end
        if (ctl.emit)
        begin
            out_status_reg <= res_status_reg;
            out_last_reg   <= res_last;
            if (!res_ok)
            begin
                out_data_reg <= '0;
                out_pos_reg  <= '0;
            end
            else if (cmd_reg == CMD_PUSH)
            begin
                out_data_reg <= value_reg;
                out_pos_reg  <= res_pos_reg;
            end
            else if (cmd_reg == CMD_DUMP)
            begin
                out_data_reg <= rd_data_reg;
                out_pos_reg  <= idx_reg;
            end
            else
            begin
                out_data_reg <= rd_data_reg;
                out_pos_reg  <= '0;
            end
        end
    end

    assign stat.out_free = out_free;
    assign stat.res_last = res_last;
    assign stat.fill     = fill_reg;

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data      = out_data_reg;
    assign position  = out_pos_reg;
    assign last      = out_last_reg;

endmodule

FILE: rtl/core/bounded_lifo_stack_core.sv
// bounded lifo stack top level: push, pop, peek and bottom-up dump of 32-bit words
// accept, execute, then emit: the result is loaded into the output register once it is free
// push/pop/peek steps: accept, memory access, result load; the next item waits for the load
// dump streams one entry per cycle after the first unless out_stall holds it (single read port)
// reset: fill count cleared, capacity set to 64; entry contents undefined until pushed
// depends on bls_pkg, bls_ctrl, bls_dpath
module bounded_lifo_stack_core
    import bls_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               cmd,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CNT_W-1:0]         capacity,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] data,
    output logic [ADDR_W-1:0]        position,
    output logic                     last
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // the user must make capacity writes only while idle; the block itself does not enforce this
    assign cfg_ready = 1'b1;

    bls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    bls_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cmd       (cmd),
        .value     (value),
        .cfg_valid (cfg_valid),
        .capacity  (capacity),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .position  (position),
        .last      (last)
    );

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input accepted on two consecutive cycles");

    a_error_result_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (data == '0 && position == '0 && last)
    ) else $error("error result carries data, position or is not last");

    a_fill_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        stat.fill <= CNT_W'(DEPTH)
    ) else $error("fill count exceeds stack depth");

endmodule

FILE: tb/bounded_lifo_stack_core_tb.sv
// testbench for bounded_lifo_stack_core: directed and random push/pop/peek/dump traffic
// scoreboard class predicts every result; depends on bls_pkg and the core rtl
`timescale 1ns / 1ps

module bounded_lifo_stack_core_tb;
    import bls_pkg::*;

    localparam int unsigned LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] data;
        logic [ADDR_W-1:0]        position;
        logic                     last;
    } stack_result_t;

    class stack_scoreboard;
        logic signed [DATA_W-1:0] words [DEPTH];
        int unsigned              fill;
        int unsigned              cap;
        stack_result_t            expected_q [$];
        int                       errors;

        function new();
            fill   = 0;
            cap    = DEPTH;
            errors = 0;
        endfunction

        function void set_capacity(input logic [CNT_W-1:0] v);
            cap = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add(input status_t s, input logic signed [DATA_W-1:0] d,
                          input int unsigned p, input logic l);
            stack_result_t r;
            r.status   = s;
            r.data     = d;
            r.position = ADDR_W'(p);
            r.last     = l;
            expected_q.push_back(r);
        endfunction

        // expected results of one accepted transaction
        function void note_command(input cmd_t c, input logic signed [DATA_W-1:0] v);
            int unsigned usable;
            usable = (cap > DEPTH) ? DEPTH : cap;
            case (c)
                CMD_PUSH:
                    if (fill >= usable)
                        add(ST_FULL, '0, 0, 1'b1);
                    else
                    begin
                        words[fill] = v;
                        add(ST_OK, v, fill, 1'b1);
                        fill++;
                    end
                CMD_POP:
                    if (fill == 0)
                        add(ST_EMPTY, '0, 0, 1'b1);
                    else
                    begin
                        fill--;
                        add(ST_OK, words[fill], 0, 1'b1);
                    end
                CMD_PEEK:
                    if (fill == 0)
                        add(ST_EMPTY, '0, 0, 1'b1);
                    else
                        add(ST_OK, words[fill - 1], 0, 1'b1);
                default:
                    if (fill == 0)
                        add(ST_EMPTY, '0, 0, 1'b1);
                    else
                        for (int unsigned i = 0; i < fill; i++)
                            add(ST_OK, words[i], i, (i + 1 == fill));
            endcase
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(input logic [1:0] st, input logic signed [DATA_W-1:0] d,
                          input logic [ADDR_W-1:0] p, input logic l);
            stack_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing expected (status %0d data %0d)", st, d));
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.status)
                report($sformatf("status %0d, expected %0d", st, want.status));
            if (d !== want.data)
                report($sformatf("data %0d, expected %0d", d, want.data));
            if (p !== want.position)
                report($sformatf("position %0d, expected %0d", p, want.position));
            if (l !== want.last)
                report($sformatf("last %0b, expected %0b", l, want.last));
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               cmd = CMD_PUSH;
    logic signed [DATA_W-1:0] value = '0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         capacity = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [ADDR_W-1:0]        position;
    logic                     last;

    stack_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b0;
    logic [1:0]  stall_mode = 2'd0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_phase = 0;

    bounded_lifo_stack_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .capacity  (capacity),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .position  (position),
        .last      (last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("bounded_lifo_stack_core regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, data, position, last);
    end

    // receiver stall: long hold-off on request, otherwise the current mode
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                2'd0:    out_stall <= 1'b0;
                2'd1:    out_stall <= ($urandom_range(2) == 0);
                default: out_stall <= ((stall_phase % 5) < 2);
            endcase
        end
        stall_phase <= stall_phase + 1;
    end

    task automatic offer(input cmd_t c, input logic signed [DATA_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        do @(posedge clk); while (in_stall);
        sb.note_command(c, v);
    endtask

    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic settle_and_configure(input logic [CNT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        capacity  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(v);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_t pick_command(input int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            return CMD_PUSH;
        r = $urandom_range(3);
        if (r < 2)
            return CMD_POP;
        return (r == 2) ? CMD_PEEK : CMD_DUMP;
    endfunction

    task automatic random_run(input int n, input int push_pct);
        repeat (n) offer(pick_command(push_pct), pick_word());
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack, reset capacity, then extreme words
        offer(CMD_POP, 32'sd5);
        offer(CMD_PEEK, 32'sd5);
        offer(CMD_DUMP, 32'sd5);
        offer(CMD_PUSH, 32'sh7fff_ffff);
        offer(CMD_PUSH, 32'sh8000_0000);
        offer(CMD_PUSH, '0);
        offer(CMD_PUSH, -1);
        offer(CMD_PUSH, 32'sh5555_5555);
        offer(CMD_PUSH, 32'shaaaa_aaaa);
        offer(CMD_PEEK, '0);
        offer(CMD_DUMP, '0);
        offer(CMD_POP, '0);
        offer(CMD_POP, '0);

        // capacity lowered below the fill: pushes refused, stored words still visible
        settle_and_configure(7'd2);
        offer(CMD_PUSH, 32'sd77);
        offer(CMD_PEEK, '0);
        offer(CMD_DUMP, '0);
        offer(CMD_POP, '0);
        offer(CMD_POP, '0);
        offer(CMD_POP, '0);
        offer(CMD_PUSH, 32'sd123);
        offer(CMD_PUSH, 32'sd456);

        // zero capacity refuses every push
        settle_and_configure(7'd0);
        offer(CMD_PUSH, 32'sd9);
        offer(CMD_POP, '0);
        offer(CMD_POP, '0);
        offer(CMD_POP, '0);

        // capacity above depth saturates: fill all entries, overflow, full dump
        settle_and_configure(7'd127);
        gaps_on = 1'b1;
        stall_mode <= 2'd2;
        while (sb.fill < DEPTH)
            offer(CMD_PUSH, pick_word());
        offer(CMD_PUSH, pick_word());
        offer(CMD_DUMP, pick_word());
        offer(CMD_PEEK, pick_word());

        settle_and_configure(7'd1);
        stall_mode <= 2'd1;
        random_run(15, 50);

        // no idling on either side
        settle_and_configure(7'd64);
        gaps_on = 1'b0;
        stall_mode <= 2'd0;
        random_run(12, 40);

        // long receiver hold-off while the sender keeps issuing commands
        settle_and_configure(7'd100);
        gaps_on = 1'b1;
        stall_mode <= 2'd1;
        hold_toggle <= ~hold_toggle;
        random_run(25, 60);

        settle_and_configure(CNT_W'($urandom_range(2, 63)));
        stall_mode <= 2'd2;
        random_run(12, 45);

        settle_and_configure(CNT_W'($urandom_range(127)));
        stall_mode <= 2'd1;
        random_run(14, 50);

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("bounded_lifo_stack_core regression: pass");
        else
            $display("bounded_lifo_stack_core regression: fail");
        $finish;
    end

endmodule
